FILE: hw/rtl/lepc_pkg.sv
`timescale 1ns / 1ps

package lepc_pkg;

  localparam int unsigned CfgW  = 11;
  localparam int unsigned ChanW = 8;
  localparam int unsigned PixW  = 3 * ChanW;
  localparam int unsigned CntW  = 21;

  localparam logic [CntW-1:0]  TallyMax     = '1;
  localparam logic [PixW-1:0]  OutsidePixel = '1;
  localparam logic [ChanW+2:0] EdgeLimit    = 11'd100;

  localparam logic [0:0] RegFrameWidth  = 1'b0;
  localparam logic [0:0] RegFrameHeight = 1'b1;

  typedef logic [PixW-1:0] pixel_t;

  typedef struct packed {
    logic [ChanW-1:0] red_value;
    logic [ChanW-1:0] green_value;
    logic [ChanW-1:0] blue_value;
  } pixel_req_t;

  typedef struct packed {
    logic [CntW-1:0] edge_pixel_count;
    logic            many_edges;
  } count_rsp_t;

  typedef struct packed {
    pixel_t older;
    pixel_t recent;
  } line_entry_t;

  // All three channels must satisfy up + down + left + right > 4 * centre + 100.
  function automatic logic is_edge(pixel_t up, pixel_t down, pixel_t left, pixel_t right,
                                   pixel_t centre);
    logic [ChanW+1:0] ring;
    logic [ChanW+2:0] mid;
    logic             hit;
    int               k;
    hit = 1'b1;
    for (k = 0; k < 3; k++) begin
      ring = {2'b00, up[k*ChanW +: ChanW]} + {2'b00, down[k*ChanW +: ChanW]}
           + {2'b00, left[k*ChanW +: ChanW]} + {2'b00, right[k*ChanW +: ChanW]};
      mid  = {1'b0, centre[k*ChanW +: ChanW], 2'b00} + EdgeLimit;
      if ({1'b0, ring} <= mid) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

endpackage

FILE: hw/rtl/laplacian_edge_pixel_counter.sv
`timescale 1ns / 1ps

// After its last pixel request is accepted, a frame's result passes through s1, s2, cnt_q and out_q.
// Throughput: one pixel per cycle, set by the single read and write port of the line memory.
// The last pixel of a frame waits while the previous frame's result is still in flight or
// stalled at the output.
// Reset clears the positions, the tally and the output valid; the registers return to 1024.
// The line memory is not cleared; its entries are always written before they are used.
module laplacian_edge_pixel_counter #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [0:0]              cfg_index_i,
  input  logic [10:0]             cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  lepc_pkg::pixel_req_t    in_req_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output lepc_pkg::count_rsp_t    out_rsp_o
);

  import lepc_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned AreaW = WW + HW;
  localparam int unsigned ProdW = CntW + 6;
  localparam int unsigned CmpW  = (AreaW > ProdW) ? AreaW : ProdW;

  localparam logic [WW-1:0] MaxW = WW'(MAX_WIDTH);
  localparam logic [HW-1:0] MaxH = HW'(MAX_HEIGHT);

  typedef struct packed {
    pixel_t        px;
    logic [AW-1:0] col;
    logic          row_ge1;
    logic          row_ge2;
    logic          col_ge1;
    logic          col_ge2;
    logic          col_last;
    logic          row_last;
    logic          last;
    logic          restart;
  } s1_t;

  typedef struct packed {
    logic [2:0] hits;
    logic       last;
    logic       restart;
  } s2_t;

  logic [CfgW-1:0] frame_width_q, frame_height_q;
  logic [WW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;
  logic [AreaW-1:0] area_q;

  logic [AW-1:0] col_q, col_d, c_eff;
  logic [RW-1:0] row_q, row_d, r_eff;
  logic          restart, col_last, row_last, last_px, in_acc, busy_last;

  line_entry_t   mem [MAX_WIDTH];
  line_entry_t   mem_rdata_q, fwd_data_q, entry, wr_entry;
  logic          fwd_q;

  logic          s1_valid_q, s2_valid_q, fin_valid_q, out_valid_q;
  s1_t           s1_q;
  s2_t           s2_q, s2_d;
  pixel_t        w1_px_q, w2_px_q, w1_rec_q, w2_rec_q, w1_old_q;
  logic          hit_x, hit_y, hit_z, hit_w;

  logic [CntW-1:0] tally_q, tally_d, base, sat, cnt_q;
  logic [CntW:0]   sum;
  count_rsp_t      out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= 11'd1024;
      frame_height_q <= 11'd1024;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegFrameWidth:  frame_width_q  <= cfg_wdata_i;
        RegFrameHeight: frame_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = WW'(1);
    end else if (frame_width_q > MAX_WIDTH) begin
      w_eff = MaxW;
    end else begin
      w_eff = WW'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      h_eff = HW'(1);
    end else if (frame_height_q > MAX_HEIGHT) begin
      h_eff = MaxH;
    end else begin
      h_eff = HW'(frame_height_q);
    end
  end

  always_ff @(posedge clk_i) begin
    area_q <= AreaW'(w_eff) * AreaW'(h_eff);
  end

  // A position that no longer fits the frame starts a new frame at this pixel.
  always_comb begin
    restart   = (WW'(col_q) >= w_eff) || (HW'(row_q) >= h_eff);
    c_eff     = restart ? '0 : col_q;
    r_eff     = restart ? '0 : row_q;
    col_last  = (WW'(c_eff) == (w_eff - WW'(1)));
    row_last  = (HW'(r_eff) == (h_eff - HW'(1)));
    last_px   = col_last && row_last;
    busy_last = (s1_valid_q && s1_q.last) || (s2_valid_q && s2_q.last) || fin_valid_q
              || (out_valid_q && out_stall_i);
    in_stall_o = last_px && busy_last;
    in_acc     = in_valid_i && !in_stall_o;
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (last_px) begin
        col_d = '0;
        row_d = '0;
      end else if (col_last) begin
        col_d = '0;
        row_d = r_eff + RW'(1);
      end else begin
        col_d = c_eff + AW'(1);
        row_d = r_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.px       <= pixel_t'(in_req_i);
      s1_q.col      <= c_eff;
      s1_q.row_ge1  <= (r_eff != '0);
      s1_q.row_ge2  <= (r_eff > RW'(1));
      s1_q.col_ge1  <= (c_eff != '0);
      s1_q.col_ge2  <= (c_eff > AW'(1));
      s1_q.col_last <= col_last;
      s1_q.row_last <= row_last;
      s1_q.last     <= last_px;
      s1_q.restart  <= restart;
    end
  end

  // The entry written by the pixel ahead is forwarded when the read hits the same column.
  assign entry    = fwd_q ? fwd_data_q : mem_rdata_q;
  assign wr_entry = '{older: entry.recent, recent: s1_q.px};

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      mem[s1_q.col] <= wr_entry;
    end
    if (in_acc) begin
      mem_rdata_q <= mem[c_eff];
      fwd_q       <= s1_valid_q && (s1_q.col == c_eff);
      fwd_data_q  <= wr_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      w1_px_q  <= s1_q.px;
      w2_px_q  <= w1_px_q;
      w1_rec_q <= entry.recent;
      w2_rec_q <= w1_rec_q;
      w1_old_q <= entry.older;
    end
  end

  // The pixel above the left neighbour is finished once its right neighbour has been read.
  always_comb begin
    hit_x = s1_q.row_ge1 && s1_q.col_ge1
         && is_edge(s1_q.row_ge2 ? w1_old_q : OutsidePixel, w1_px_q,
                    s1_q.col_ge2 ? w2_rec_q : OutsidePixel, entry.recent, w1_rec_q);
    hit_y = s1_q.row_ge1 && s1_q.col_last
         && is_edge(s1_q.row_ge2 ? entry.older : OutsidePixel, s1_q.px,
                    s1_q.col_ge1 ? w1_rec_q : OutsidePixel, OutsidePixel, entry.recent);
    hit_z = s1_q.row_last && s1_q.col_ge1
         && is_edge(s1_q.row_ge1 ? w1_rec_q : OutsidePixel, OutsidePixel,
                    s1_q.col_ge2 ? w2_px_q : OutsidePixel, s1_q.px, w1_px_q);
    hit_w = s1_q.row_last && s1_q.col_last
         && is_edge(s1_q.row_ge1 ? entry.recent : OutsidePixel, OutsidePixel,
                    s1_q.col_ge1 ? w1_px_q : OutsidePixel, OutsidePixel, s1_q.px);
    s2_d.hits    = 3'({2'b00, hit_x}) + 3'({2'b00, hit_y}) + 3'({2'b00, hit_z})
                 + 3'({2'b00, hit_w});
    s2_d.last    = s1_q.last;
    s2_d.restart = s1_q.restart;
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  always_comb begin
    base    = s2_q.restart ? '0 : tally_q;
    sum     = {1'b0, base} + (CntW + 1)'(s2_q.hits);
    sat     = sum[CntW] ? TallyMax : sum[CntW-1:0];
    tally_d = tally_q;
    if (s2_valid_q) begin
      tally_d = s2_q.last ? '0 : sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && s2_q.last) begin
      cnt_q <= sat;
    end
    if (fin_valid_q) begin
      out_q.edge_pixel_count <= cnt_q;
      out_q.many_edges <= (CmpW'({cnt_q, 5'b00000}) + CmpW'({cnt_q, 3'b000}))
                        > CmpW'(area_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      tally_q     <= '0;
    end else begin
      s1_valid_q  <= in_acc;
      s2_valid_q  <= s1_valid_q;
      fin_valid_q <= s2_valid_q && s2_q.last;
      tally_q     <= tally_d;
      if (fin_valid_q) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_fin_into_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_valid_q |-> !out_valid_q)
    else $error("frame result reached a full output register");

  a_last_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_px) |-> ##4 out_valid_o)
    else $error("frame result did not appear four cycles after the last pixel");

  a_last_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_px) |=> (col_q == '0 && row_q == '0))
    else $error("position did not return to the frame start");

  a_one_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({s1_valid_q && s1_q.last, s2_valid_q && s2_q.last, fin_valid_q, out_valid_q}))
    else $error("more than one frame result in flight");

endmodule

FILE: tb/tb_laplacian_edge_pixel_counter.sv
`timescale 1ns / 1ps

module tb_laplacian_edge_pixel_counter;
  import lepc_pkg::*;

  localparam int unsigned MaxWidth     = 1024;
  localparam int unsigned MaxHeight    = 1024;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned RandomPixels = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_index_i;
  logic [10:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  pixel_req_t  in_req_i;
  logic        out_valid_o;
  logic        out_stall_i;
  count_rsp_t  out_rsp_o;

  laplacian_edge_pixel_counter #(
    .MAX_WIDTH (MaxWidth),
    .MAX_HEIGHT(MaxHeight)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  logic [10:0]     frame_w = 11'd1024;
  logic [10:0]     frame_h = 11'd1024;
  pixel_t          older_row [MaxWidth];
  pixel_t          recent_row [MaxWidth];
  int unsigned     col_pos = 0;
  int unsigned     row_pos = 0;
  logic [CntW-1:0] tally = '0;
  pixel_t          win0 = '0;
  pixel_t          win1 = '0;

  count_rsp_t      expected_counts [$];
  count_rsp_t      wanted;

  int unsigned     errors = 0;
  int unsigned     pixels_sent = 0;
  int unsigned     frames_checked = 0;
  int unsigned     flagged_frames = 0;
  int unsigned     frame_restarts = 0;
  bit              quiet = 1'b0;
  int unsigned     rx_hold_req = 0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic int unsigned eff_size(input logic [10:0] v, input int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic bit laplace_hit(input pixel_t up, input pixel_t dn, input pixel_t lf,
                                     input pixel_t rt, input pixel_t ct);
    int sum;
    int k;
    for (k = 0; k < 3; k++) begin
      sum = int'(up[8*k +: 8]) + int'(dn[8*k +: 8]) + int'(lf[8*k +: 8])
          + int'(rt[8*k +: 8]) - 4 * int'(ct[8*k +: 8]);
      if (sum <= 100) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic pixel_req_t random_pixel();
    pixel_req_t p;
    int unsigned kind;
    kind = $urandom_range(2, 0);
    p = pixel_req_t'(24'($urandom));
    if (kind == 0) p = p & 24'h3f3f3f;
    else if (kind == 1) p = p | 24'hc0c0c0;
    return p;
  endfunction

  task automatic tally_pixel(input pixel_t px);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    pixel_t      up;
    pixel_t      lf;
    pixel_t      rt;
    count_rsp_t  rsp;
    w = eff_size(frame_w, MaxWidth);
    h = eff_size(frame_h, MaxHeight);
    if (col_pos >= w || row_pos >= h) begin
      col_pos = 0;
      row_pos = 0;
      tally = '0;
      frame_restarts++;
    end
    c = col_pos;
    r = row_pos;
    if (c == 0) begin
      win0 = '0;
      win1 = '0;
    end
    if (r >= 1) begin
      up = (r >= 2) ? older_row[c] : OutsidePixel;
      lf = (c >= 1) ? older_row[c-1] : OutsidePixel;
      rt = (c + 1 < w) ? recent_row[c+1] : OutsidePixel;
      if (laplace_hit(up, px, lf, rt, recent_row[c]) && tally != TallyMax) tally++;
    end
    older_row[c] = recent_row[c];
    recent_row[c] = px;
    if (r == h - 1) begin
      if (c >= 1) begin
        up = (r >= 1) ? older_row[c-1] : OutsidePixel;
        lf = (c >= 2) ? win1 : OutsidePixel;
        if (laplace_hit(up, OutsidePixel, lf, px, win0) && tally != TallyMax) tally++;
      end
      if (c == w - 1) begin
        up = (r >= 1) ? older_row[c] : OutsidePixel;
        lf = (c >= 1) ? win0 : OutsidePixel;
        if (laplace_hit(up, OutsidePixel, lf, OutsidePixel, px) && tally != TallyMax) tally++;
        rsp.edge_pixel_count = tally;
        rsp.many_edges = (40 * longint'(tally) > longint'(w) * longint'(h));
        expected_counts.push_back(rsp);
        col_pos = 0;
        row_pos = 0;
        tally = '0;
        win0 = '0;
        win1 = '0;
        return;
      end
    end
    win1 = win0;
    win0 = px;
    if (c + 1 < w) begin
      col_pos = c + 1;
    end else begin
      col_pos = 0;
      row_pos = r + 1;
    end
  endtask

  task automatic send_pixel(input pixel_req_t px);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(7, 0);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_req_i   <= px;
    do @(posedge clk_i); while (in_stall_o);
    pixels_sent++;
    tally_pixel(px);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [10:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegFrameWidth) frame_w = val;
    else frame_h = val;
  endtask

  task automatic set_frame(input logic [10:0] w, input logic [10:0] h);
    write_reg(RegFrameWidth, w);
    write_reg(RegFrameHeight, h);
  endtask

  task automatic send_frames(input int unsigned n);
    int unsigned total;
    total = n * eff_size(frame_w, MaxWidth) * eff_size(frame_h, MaxHeight);
    repeat (total) send_pixel(random_pixel());
  endtask

  task automatic test_single_pixel_frames();
    set_frame(11'd0, 11'd0);
    send_pixel(24'h000000);
    send_pixel(24'hffffff);
    send_pixel(24'h00ff00);
    send_pixel(24'h5a5a5a);
    wait_drained();
  endtask

  task automatic test_thin_frames();
    set_frame(11'd5, 11'd1);
    send_pixel(24'hffffff);
    send_pixel(24'h000000);
    send_pixel(24'hffffff);
    send_pixel(24'h000000);
    send_pixel(24'h808080);
    wait_drained();
    set_frame(11'd1, 11'd4);
    send_pixel(24'h000000);
    send_pixel(24'hffffff);
    send_pixel(24'h0000ff);
    send_pixel(24'h101010);
    wait_drained();
    set_frame(11'd3, 11'd3);
    send_pixel(24'hffffff);
    send_pixel(24'hffffff);
    send_pixel(24'hffffff);
    send_pixel(24'hffffff);
    send_pixel(24'h000000);
    send_pixel(24'hffffff);
    send_pixel(24'hffffff);
    send_pixel(24'hffffff);
    send_pixel(24'hffffff);
    wait_drained();
  endtask

  task automatic test_full_size_frames();
    set_frame(11'd2047, 11'd1);
    quiet = 1'b1;
    send_frames(1);
    quiet = 1'b0;
    wait_drained();
  endtask

  task automatic test_size_change_restart();
    set_frame(11'd4, 11'd3);
    repeat (6) send_pixel(random_pixel());
    wait_drained();
    write_reg(RegFrameWidth, 11'd2);
    send_frames(1);
    wait_drained();
    set_frame(11'd3, 11'd4);
    repeat (7) send_pixel(random_pixel());
    wait_drained();
    write_reg(RegFrameHeight, 11'd2);
    send_frames(1);
    wait_drained();
    repeat (4) send_pixel(random_pixel());
    wait_drained();
    write_reg(RegFrameHeight, 11'd3);
    repeat (5) send_pixel(random_pixel());
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    set_frame(11'd1, 11'd1);
    quiet = 1'b1;
    rx_hold_req = 100;
    repeat (24) send_pixel(random_pixel());
    wait_drained();
    set_frame(11'd2, 11'd1);
    rx_hold_req = 60;
    send_frames(12);
    quiet = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_frames();
    int unsigned start;
    start = pixels_sent;
    while (pixels_sent - start < RandomPixels) begin
      if ($urandom_range(9, 0) < 8) begin
        set_frame(11'($urandom_range(6, 0)), 11'($urandom_range(6, 0)));
      end else begin
        set_frame(11'($urandom_range(10, 0)), 11'($urandom_range(10, 0)));
      end
      quiet = ($urandom_range(3, 0) == 0);
      send_frames($urandom_range(4, 1));
      quiet = 1'b0;
      wait_drained();
    end
  endtask

  // The receiver may pause after an accepted result unless quiet is set; a long hold lets results back up.
  initial begin
    int unsigned stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req != 0) begin
        stall_left  = rx_hold_req;
        rx_hold_req = 0;
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) stall_left = quiet ? 0 : $urandom_range(7, 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_counts.size() == 0) begin
        $error("edge_pixel_count: expected no result, actual %0d", out_rsp_o.edge_pixel_count);
        errors++;
      end else begin
        wanted = expected_counts.pop_front();
        frames_checked++;
        if (wanted.many_edges) flagged_frames++;
        if (out_rsp_o.edge_pixel_count !== wanted.edge_pixel_count) begin
          $error("edge_pixel_count: expected %0d, actual %0d",
                 wanted.edge_pixel_count, out_rsp_o.edge_pixel_count);
          errors++;
        end
        if (out_rsp_o.many_edges !== wanted.many_edges) begin
          $error("many_edges: expected %0b, actual %0b", wanted.many_edges, out_rsp_o.many_edges);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_single_pixel_frames();
    test_thin_frames();
    test_full_size_frames();
    test_size_change_restart();
    test_output_backpressure();
    test_random_frames();
    wait_drained();

    $display("Checked %0d frame counts over %0d pixel requests; %0d frames had many edges.",
             frames_checked, pixels_sent, flagged_frames);
    $display("Sizes ranged from one pixel to a full clamped row; %0d frames restarted.",
             frame_restarts);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/lepc_pkg.sv
hw/rtl/laplacian_edge_pixel_counter.sv
tb/tb_laplacian_edge_pixel_counter.sv
